[hdl/integral_image_builder_macros.svh]
// Assertion macros for the checker file of the integral image builder.
// No dependencies; include by bare file name.
`ifndef INTEGRAL_IMAGE_BUILDER_MACROS_SVH
`define INTEGRAL_IMAGE_BUILDER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define IIB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("iib check failed");

// Next-cycle implication, disabled while reset is asserted
`define IIB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("iib check failed");

`endif

[hdl/iib_pkg.sv]
// Package for the integral image builder: register indexes, reset values and fixed field widths.
// No dependencies.
package iib_pkg;

	// configuration port geometry
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 12;

	// payload widths
	localparam int PIX_BITS   = 8;
	localparam int COORD_BITS = 10;
	localparam int SUM_W      = 32;

	// register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_SRC_WIDTH  = 3'd0,
		REG_SRC_HEIGHT = 3'd1,
		REG_SCALE      = 3'd2,
		REG_OUT_WIDTH  = 3'd3,
		REG_OUT_HEIGHT = 3'd4,
		REG_CHANNEL    = 3'd5
	} cfg_reg_t;

	// register reset values
	localparam logic [11:0] SRC_WIDTH_RST  = 12'd640;
	localparam logic [11:0] SRC_HEIGHT_RST = 12'd480;
	localparam logic [3:0]  SCALE_RST      = 4'd1;
	localparam logic [10:0] OUT_WIDTH_RST  = 11'd640;
	localparam logic [10:0] OUT_HEIGHT_RST = 11'd480;

endpackage

[hdl/integral_image_builder.sv]
// Integral image builder top level: decimation counters, line store and output register.
// Depends on iib_pkg and iib_ram.
//
//  channel  | signals                              | role
//  ---------+--------------------------------------+------------------------------
//  pixel in | in_valid, in_ready, cb, cr           | raster-order source pixels
//  sum out  | out_valid, out_ready, sum, out_row,  | one value per kept pixel
//           | out_col, last                        |
//  config   | cfg_wen, cfg_index, cfg_data         | register writes, no read-back
//
// One pixel transfer per cycle sustained while in_ready is high; a kept pixel's value passes
// the read stage (line store read), then the add into the output register.
// The line store has one read and one write port; a read of the entry written in the
// same cycle is served from a forwarding register.
// in_ready drops only while both the output register and the read stage hold values and
// out_ready is low. Reset clears counters and valid flags; the line store needs no clearing.
module integral_image_builder #(
	parameter int MAX_OUT_WIDTH = 1024,
	parameter int SUM_BITS      = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// pixel input
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [iib_pkg::PIX_BITS-1:0]    cb,
	input  logic [iib_pkg::PIX_BITS-1:0]    cr,
	// sum output
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [iib_pkg::SUM_W-1:0]       sum,
	output logic [iib_pkg::COORD_BITS-1:0]  out_row,
	output logic [iib_pkg::COORD_BITS-1:0]  out_col,
	output logic                            last,
	// configuration
	input  logic                            cfg_wen,
	input  logic [iib_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [iib_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	localparam int AW      = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
	localparam int COL_CAP = (MAX_OUT_WIDTH < 1024) ? MAX_OUT_WIDTH : 1024;
	localparam int PIX_BITS_L = iib_pkg::PIX_BITS;

	// configuration registers
	logic [11:0] src_width_q, src_height_q;
	logic [3:0]  scale_q;
	logic [10:0] out_width_q, out_height_q;
	logic        channel_q;

	// effective sizes after clamping
	logic [3:0]  s_eff;
	logic [11:0] w_eff, h_eff;
	logic [10:0] ow_eff, oh_eff;

	// position counters
	logic [10:0] src_col_q, src_row_q;
	logic [2:0]  col_phase_q, row_phase_q;
	logic [10:0] out_col_q, out_row_q;
	logic [SUM_BITS-1:0] row_sum_q;

	// next-state terms
	logic        acc, keep, row_end, frame_end;
	logic [3:0]  col_ph_inc, row_ph_inc;
	logic [11:0] src_col_inc, src_row_inc;
	logic [PIX_BITS_L-1:0] pix;
	logic [SUM_BITS-1:0] row_sum_nxt;
	logic [AW+10:0] col_ext;
	logic [AW-1:0]  idx;

	// read stage
	logic                s1_valid_q;
	logic [SUM_BITS-1:0] rowsum_s1;
	logic [AW-1:0]       idx_s1;
	logic                row0_s1;
	logic [9:0]          row_s1, col_s1;
	logic                last_s1;
	logic                advance;

	// line store and forwarding
	logic [SUM_BITS-1:0] rdata;
	logic [SUM_BITS-1:0] above, total;
	logic                fwd_valid_q;
	logic [AW-1:0]       fwd_idx_q;
	logic [SUM_BITS-1:0] fwd_data_q;

	// output register
	logic                out_valid_q;
	logic [SUM_BITS-1:0] sum_q;
	logic [9:0]          out_row_q10, out_col_q10;
	logic                last_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= iib_pkg::SRC_WIDTH_RST;
			src_height_q <= iib_pkg::SRC_HEIGHT_RST;
			scale_q      <= iib_pkg::SCALE_RST;
			out_width_q  <= iib_pkg::OUT_WIDTH_RST;
			out_height_q <= iib_pkg::OUT_HEIGHT_RST;
			channel_q    <= 1'b0;
		end else if (cfg_wen) begin
			unique case (iib_pkg::cfg_reg_t'(cfg_index))
				iib_pkg::REG_SRC_WIDTH:  src_width_q  <= cfg_data;
				iib_pkg::REG_SRC_HEIGHT: src_height_q <= cfg_data;
				iib_pkg::REG_SCALE:      scale_q      <= cfg_data[3:0];
				iib_pkg::REG_OUT_WIDTH:  out_width_q  <= cfg_data[10:0];
				iib_pkg::REG_OUT_HEIGHT: out_height_q <= cfg_data[10:0];
				iib_pkg::REG_CHANNEL:    channel_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// clamp registers to their working ranges
	always_comb begin
		s_eff  = (scale_q == 4'd0) ? 4'd1 : ((scale_q > 4'd8) ? 4'd8 : scale_q);
		w_eff  = (src_width_q == 12'd0) ? 12'd1 :
		         ((src_width_q > 12'd2048) ? 12'd2048 : src_width_q);
		h_eff  = (src_height_q == 12'd0) ? 12'd1 :
		         ((src_height_q > 12'd2048) ? 12'd2048 : src_height_q);
		ow_eff = (out_width_q == 11'd0) ? 11'd1 :
		         ((out_width_q > 11'(COL_CAP)) ? 11'(COL_CAP) : out_width_q);
		oh_eff = (out_height_q == 11'd0) ? 11'd1 :
		         ((out_height_q > 11'd1024) ? 11'd1024 : out_height_q);
	end

	// kept-pixel decision and counter increments
	assign acc         = in_valid && in_ready;
	assign keep        = (row_phase_q == 3'd0) && (col_phase_q == 3'd0) &&
	                     (out_col_q < ow_eff) && (out_row_q < oh_eff);
	assign pix         = channel_q ? cr : cb;
	assign row_sum_nxt = row_sum_q + SUM_BITS'(pix);
	assign col_ph_inc  = {1'b0, col_phase_q} + 4'd1;
	assign row_ph_inc  = {1'b0, row_phase_q} + 4'd1;
	assign src_col_inc = {1'b0, src_col_q} + 12'd1;
	assign src_row_inc = {1'b0, src_row_q} + 12'd1;
	assign row_end     = src_col_inc >= w_eff;
	assign frame_end   = row_end && (src_row_inc >= h_eff);
	assign col_ext     = {{AW{1'b0}}, out_col_q};
	assign idx         = col_ext[AW-1:0];

	// position counters and row running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q   <= '0;
			src_row_q   <= '0;
			col_phase_q <= '0;
			row_phase_q <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			row_sum_q   <= '0;
		end else if (acc) begin
			if (row_end) begin
				src_col_q   <= '0;
				col_phase_q <= '0;
				out_col_q   <= '0;
				row_sum_q   <= '0;
				if (frame_end) begin
					src_row_q   <= '0;
					row_phase_q <= '0;
					out_row_q   <= '0;
				end else begin
					src_row_q   <= src_row_inc[10:0];
					row_phase_q <= (row_ph_inc >= s_eff) ? 3'd0 : row_ph_inc[2:0];
					if (row_phase_q == 3'd0 && out_row_q < 11'd1024) begin
						out_row_q <= out_row_q + 11'd1;
					end
				end
			end else begin
				src_col_q   <= src_col_inc[10:0];
				col_phase_q <= (col_ph_inc >= s_eff) ? 3'd0 : col_ph_inc[2:0];
				if (col_phase_q == 3'd0 && out_col_q < 11'(COL_CAP)) begin
					out_col_q <= out_col_q + 11'd1;
				end
				if (keep) begin
					row_sum_q <= row_sum_nxt;
				end
			end
		end
	end

	// read stage: holds a kept pixel while its line-store entry is fetched
	assign advance  = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (acc && keep) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && keep) begin
			rowsum_s1 <= row_sum_nxt;
			idx_s1    <= idx;
			row0_s1   <= (out_row_q == 11'd0);
			row_s1    <= out_row_q[9:0];
			col_s1    <= out_col_q[9:0];
			last_s1   <= (out_row_q == oh_eff - 11'd1) && (out_col_q == ow_eff - 11'd1);
		end
	end

	// line store of the previous output row
	iib_ram #(
		.WIDTH (SUM_BITS),
		.DEPTH (MAX_OUT_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (advance),
		.waddr (idx_s1),
		.wdata (total),
		.re    (acc && keep),
		.raddr (idx),
		.rdata (rdata)
	);

	// value above: zero on the first row, forwarded if written at the read edge
	always_comb begin
		if (row0_s1) begin
			above = '0;
		end else if (fwd_valid_q && fwd_idx_q == idx_s1) begin
			above = fwd_data_q;
		end else begin
			above = rdata;
		end
		total = rowsum_s1 + above;
	end

	// last write into the line store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (advance) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fwd_idx_q  <= idx_s1;
			fwd_data_q <= total;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sum_q       <= total;
			out_row_q10 <= row_s1;
			out_col_q10 <= col_s1;
			last_q      <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign sum       = iib_pkg::SUM_W'(sum_q);
	assign out_row   = out_row_q10;
	assign out_col   = out_col_q10;
	assign last      = last_q;

endmodule

[hdl/iib_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module iib_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hdl/iib_checker.sv]
// Port-level checks for the integral image builder, bound to the top level.
// Depends on iib_pkg and integral_image_builder_macros.svh.
`include "integral_image_builder_macros.svh"

module iib_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic [iib_pkg::PIX_BITS-1:0]      cb,
	input logic [iib_pkg::PIX_BITS-1:0]      cr,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [iib_pkg::SUM_W-1:0]         sum,
	input logic [iib_pkg::COORD_BITS-1:0]    out_row,
	input logic [iib_pkg::COORD_BITS-1:0]    out_col,
	input logic                              last,
	input logic                              cfg_wen,
	input logic [iib_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input logic [iib_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	// a stalled result holds its value until the transfer
	`IIB_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(sum) && $stable(out_row) && $stable(out_col))

	// a stalled result keeps its last flag
	`IIB_ASSERT_NEXT(a_out_stay, clk, arst_n, out_valid && !out_ready, $stable(last))

	// input back-pressure only comes from a blocked, occupied output
	`IIB_ASSERT_NOW(a_ready_cause, clk, arst_n, !in_ready, out_valid && !out_ready)

	// the corner value of a frame is a single chroma byte
	`IIB_ASSERT_NOW(a_origin_sum, clk, arst_n, out_valid && out_row == '0 && out_col == '0, sum <= 32'd255)

endmodule

bind integral_image_builder iib_checker u_iib_checker (.*);

[tb/tb_integral_image_builder.sv]
// Testbench for integral_image_builder: raster frames of Cb/Cr pixels against a
// behavioural summed-area predictor, with register writes between frames.
// Depends on iib_pkg and the integral_image_builder RTL.
module tb_integral_image_builder;
	import iib_pkg::*;

	localparam int LINE_DEPTH       = 1024;
	localparam int CYCLE_LIMIT      = 400000;
	localparam int PIXELS_PER_MODE  = 140;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES    = 8;
	localparam int PLAN_LEN         = 40;

	// one value leaving the sum channel
	typedef struct packed {
		logic [SUM_W-1:0]      total;
		logic [COORD_BITS-1:0] row;
		logic [COORD_BITS-1:0] col;
		logic                  last;
	} area_sum_t;

	typedef enum logic {STEP_PIXEL, STEP_WRITE} step_kind_t;

	// directed step: a pixel transfer or a register write
	typedef struct packed {
		step_kind_t               kind;
		cfg_reg_t                 reg_idx;
		logic [CFG_DATA_BITS-1:0] value;
		logic [PIX_BITS-1:0]      cb_v;
		logic [PIX_BITS-1:0]      cr_v;
		logic                     typed;
		area_sum_t                want;
	} plan_step_t;

	localparam area_sum_t NO_SUM = '0;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// block ports
	logic                     in_valid  = 1'b0;
	logic                     in_ready;
	logic [PIX_BITS-1:0]      cb        = '0;
	logic [PIX_BITS-1:0]      cr        = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [SUM_W-1:0]         sum;
	logic [COORD_BITS-1:0]    out_row;
	logic [COORD_BITS-1:0]    out_col;
	logic                     last;
	logic                     cfg_wen   = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

	// predictor copy of the registers
	logic [11:0] src_w_reg = SRC_WIDTH_RST;
	logic [11:0] src_h_reg = SRC_HEIGHT_RST;
	logic [3:0]  scale_reg = SCALE_RST;
	logic [10:0] out_w_reg = OUT_WIDTH_RST;
	logic [10:0] out_h_reg = OUT_HEIGHT_RST;
	logic        chan_reg  = 1'b0;

	// predictor state
	logic [SUM_W-1:0] prev_row_sums [LINE_DEPTH];
	logic [SUM_W-1:0] row_acc     = '0;
	logic [11:0]      src_col_pos = '0;
	logic [11:0]      src_row_pos = '0;
	logic [3:0]       col_step    = '0;
	logic [3:0]       row_step    = '0;
	logic [10:0]      dec_col     = '0;
	logic [10:0]      dec_row     = '0;

	area_sum_t sums_due [$];
	int        errors       = 0;
	int        cycles       = 0;
	int        pixels_sent  = 0;
	int        tx_idle_pct  = 0;
	int        rx_idle_pct  = 0;
	bit        hold_request = 1'b0;

	// directed steps; typed values hold only where they follow at a glance
	plan_step_t plan [PLAN_LEN] = '{
		// reset geometry, Cb summed along row 0
		'{STEP_PIXEL, REG_SRC_WIDTH,  12'd0,   8'h00, 8'hFF, 1'b1, '{32'd0,   10'd0, 10'd0, 1'b0}},
		'{STEP_PIXEL, REG_SRC_WIDTH,  12'd0,   8'hFF, 8'h00, 1'b1, '{32'd255, 10'd0, 10'd1, 1'b0}},
		// mid-frame shrink: the next transfer closes row and frame
		'{STEP_WRITE, REG_SRC_WIDTH,  12'd1,   8'h00, 8'h00, 1'b0, NO_SUM},
		'{STEP_WRITE, REG_SRC_HEIGHT, 12'd1,   8'h00, 8'h00, 1'b0, NO_SUM},
		'{STEP_PIXEL, REG_SRC_WIDTH,  12'd0,   8'h80, 8'h01, 1'b1, '{32'd383, 10'd0, 10'd2, 1'b0}},
		// 1x1 frames, Cr then Cb
		'{STEP_WRITE, REG_OUT_WIDTH,  12'd1,   8'h00, 8'h00, 1'b0, NO_SUM},
		'{STEP_WRITE, REG_OUT_HEIGHT, 12'd1,   8'h00, 8'h00, 1'b0, NO_SUM},
		'{STEP_WRITE, REG_CHANNEL,    12'd1,   8'h00, 8'h00, 1'b0, NO_SUM},
		'{STEP_PIXEL, REG_SRC_WIDTH,  12'd0,   8'h00, 8'hFF, 1'b1, '{32'd255, 10'd0, 10'd0, 1'b1}},
		'{STEP_PIXEL, REG_SRC_WIDTH,  12'd0,   8'hFF, 8'h00, 1'b1, '{32'd0,   10'd0, 10'd0, 1'b1}},
		'{STEP_WRITE, REG_CHANNEL,    12'd0,   8'h00, 8'h00, 1'b0, NO_SUM},
		'{STEP_PIXEL, REG_SRC_WIDTH,  12'd0,   8'hAA, 8'h55, 1'b1, '{32'hAA,  10'd0, 10'd0, 1'b1}},
		'{STEP_PIXEL, REG_SRC_WIDTH,  12'd0,   8'h55, 8'hAA, 1'b1, '{32'h55,  10'd0, 10'd0, 1'b1}},
		// zero sizes and zero scale all act as one
		'{STEP_WRITE, REG_SRC_WIDTH,  12'd0,   8'h00, 8'h00, 1'b0, NO_SUM},
		'{STEP_WRITE, REG_SRC_HEIGHT, 12'd0,   8'h00, 8'h00, 1'b0, NO_SUM},
		'{STEP_WRITE, REG_SCALE,      12'd0,   8'h00, 8'h00, 1'b0, NO_SUM},
		'{STEP_WRITE, REG_OUT_WIDTH,  12'd0,   8'h00, 8'h00, 1'b0, NO_SUM},
		'{STEP_WRITE, REG_OUT_HEIGHT, 12'd0,   8'h00, 8'h00, 1'b0, NO_SUM},
		'{STEP_PIXEL, REG_SRC_WIDTH,  12'd0,   8'h01, 8'hFE, 1'b1, '{32'd1,   10'd0, 10'd0, 1'b1}},
		// 2x2 frame, second row adds the line store
		'{STEP_WRITE, REG_SRC_WIDTH,  12'd2,   8'h00, 8'h00, 1'b0, NO_SUM},
		'{STEP_WRITE, REG_SRC_HEIGHT, 12'd2,   8'h00, 8'h00, 1'b0, NO_SUM},
		'{STEP_WRITE, REG_SCALE,      12'd1,   8'h00, 8'h00, 1'b0, NO_SUM},
		'{STEP_WRITE, REG_OUT_WIDTH,  12'd2,   8'h00, 8'h00, 1'b0, NO_SUM},
		'{STEP_WRITE, REG_OUT_HEIGHT, 12'd2,   8'h00, 8'h00, 1'b0, NO_SUM},
		'{STEP_PIXEL, REG_SRC_WIDTH,  12'd0,   8'h10, 8'h20, 1'b0, NO_SUM},
		'{STEP_PIXEL, REG_SRC_WIDTH,  12'd0,   8'h30, 8'h40, 1'b0, NO_SUM},
		'{STEP_PIXEL, REG_SRC_WIDTH,  12'd0,   8'h50, 8'h60, 1'b0, NO_SUM},
		'{STEP_PIXEL, REG_SRC_WIDTH,  12'd0,   8'h70, 8'h80, 1'b0, NO_SUM},
		// scale 15 acts as 8; output taller than the source, so no last
		'{STEP_WRITE, REG_SCALE,      12'hFFF, 8'h00, 8'h00, 1'b0, NO_SUM},
		'{STEP_WRITE, REG_SRC_WIDTH,  12'd9,   8'h00, 8'h00, 1'b0, NO_SUM},
		'{STEP_WRITE, REG_SRC_HEIGHT, 12'd1,   8'h00, 8'h00, 1'b0, NO_SUM},
		'{STEP_PIXEL, REG_SRC_WIDTH,  12'd0,   8'h11, 8'hEE, 1'b0, NO_SUM},
		'{STEP_PIXEL, REG_SRC_WIDTH,  12'd0,   8'h22, 8'hDD, 1'b0, NO_SUM},
		'{STEP_PIXEL, REG_SRC_WIDTH,  12'd0,   8'h33, 8'hCC, 1'b0, NO_SUM},
		'{STEP_PIXEL, REG_SRC_WIDTH,  12'd0,   8'h44, 8'hBB, 1'b0, NO_SUM},
		'{STEP_PIXEL, REG_SRC_WIDTH,  12'd0,   8'h55, 8'hAA, 1'b0, NO_SUM},
		'{STEP_PIXEL, REG_SRC_WIDTH,  12'd0,   8'h66, 8'h99, 1'b0, NO_SUM},
		'{STEP_PIXEL, REG_SRC_WIDTH,  12'd0,   8'h77, 8'h88, 1'b0, NO_SUM},
		'{STEP_PIXEL, REG_SRC_WIDTH,  12'd0,   8'h88, 8'h77, 1'b0, NO_SUM},
		'{STEP_PIXEL, REG_SRC_WIDTH,  12'd0,   8'h99, 8'h66, 1'b0, NO_SUM}
	};

	integral_image_builder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cb        (cb),
		.cr        (cr),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sum       (sum),
		.out_row   (out_row),
		.out_col   (out_col),
		.last      (last),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 20-unit clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int unsigned limit_range(int unsigned v, int unsigned lo, int unsigned hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// register values as the block uses them
	function automatic void effective_geometry(output int unsigned s, output int unsigned w,
			output int unsigned h, output int unsigned ow, output int unsigned oh);
		s  = limit_range(scale_reg, 1, 8);
		w  = limit_range(src_w_reg, 1, 2048);
		h  = limit_range(src_h_reg, 1, 2048);
		ow = limit_range(out_w_reg, 1, LINE_DEPTH);
		oh = limit_range(out_h_reg, 1, 1024);
	endfunction

	// advance the predictor by one pixel; returns 1 when the pixel is kept
	function automatic bit integrate_pixel(logic [PIX_BITS-1:0] c_b, logic [PIX_BITS-1:0] c_r,
			output area_sum_t res);
		int unsigned      s, w, h, ow, oh;
		logic [SUM_W-1:0] above;
		bit               kept;
		effective_geometry(s, w, h, ow, oh);
		kept = row_step == 0 && col_step == 0 && dec_col < ow && dec_row < oh;
		res  = '0;
		if (kept) begin
			row_acc   = row_acc + (chan_reg ? c_r : c_b);
			above     = (dec_row == 0) ? '0 : prev_row_sums[dec_col[9:0]];
			res.total = row_acc + above;
			prev_row_sums[dec_col[9:0]] = res.total;
			res.row   = dec_row[9:0];
			res.col   = dec_col[9:0];
			res.last  = (dec_row == oh - 1) && (dec_col == ow - 1);
		end
		// column counters
		if (col_step == 0 && dec_col < LINE_DEPTH)
			dec_col = dec_col + 1'b1;
		col_step    = (col_step + 1 >= s) ? '0 : col_step + 1'b1;
		src_col_pos = src_col_pos + 1'b1;
		// row and frame end
		if (src_col_pos >= w) begin
			src_col_pos = '0;
			col_step    = '0;
			dec_col     = '0;
			row_acc     = '0;
			if (row_step == 0 && dec_row < 1024)
				dec_row = dec_row + 1'b1;
			row_step    = (row_step + 1 >= s) ? '0 : row_step + 1'b1;
			src_row_pos = src_row_pos + 1'b1;
			if (src_row_pos >= h) begin
				src_row_pos = '0;
				row_step    = '0;
				dec_row     = '0;
			end
		end
		return kept;
	endfunction

	task automatic report_mismatch(string what);
		$display("%0t: %s", $time, what);
		errors++;
	endtask

	// one pixel transfer, with a random gap ahead of it
	task automatic send_pixel(logic [PIX_BITS-1:0] c_b, logic [PIX_BITS-1:0] c_r, bit typed,
			area_sum_t want);
		area_sum_t got;
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		in_valid <= 1'b1;
		cb       <= c_b;
		cr       <= c_r;
		do @(posedge clk); while (!(in_valid && in_ready));
		pixels_sent++;
		if (integrate_pixel(c_b, c_r, got))
			sums_due.push_back(typed ? want : got);
	endtask

	// register write once every due sum has left and the pipeline has settled
	task automatic write_register(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] v);
		in_valid <= 1'b0;
		while (sums_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		case (idx)
			REG_SRC_WIDTH:  src_w_reg = v;
			REG_SRC_HEIGHT: src_h_reg = v;
			REG_SCALE:      scale_reg = v[3:0];
			REG_OUT_WIDTH:  out_w_reg = v[10:0];
			REG_OUT_HEIGHT: out_h_reg = v[10:0];
			REG_CHANNEL:    chan_reg  = v[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic set_geometry(logic [11:0] w, logic [11:0] h, logic [3:0] s, logic [11:0] ow,
			logic [11:0] oh, logic ch);
		write_register(REG_SRC_WIDTH, w);
		write_register(REG_SRC_HEIGHT, h);
		write_register(REG_SCALE, {8'd0, s});
		write_register(REG_OUT_WIDTH, ow);
		write_register(REG_OUT_HEIGHT, oh);
		write_register(REG_CHANNEL, {11'd0, ch});
	endtask

	// one whole frame of random chroma, starting from the frame origin
	task automatic send_frame();
		int unsigned s, w, h, ow, oh;
		effective_geometry(s, w, h, ow, oh);
		repeat (w * h)
			send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0, NO_SUM);
	endtask

	// output size: mostly the decimated fit, sometimes off it or far too large
	function automatic logic [11:0] pick_out_size(int unsigned fit);
		case ($urandom_range(9))
			0:       return 12'hFFF;
			1, 2:    return 12'($urandom_range(fit + 3));
			default: return 12'(fit);
		endcase
	endfunction

	task automatic pick_geometry();
		logic [3:0]  s;
		logic [11:0] w, h;
		int unsigned es, ew, eh;
		case ($urandom_range(9))
			0:       s = 4'($urandom_range(15));
			1:       s = 4'd8;
			default: s = 4'($urandom_range(1, 3));
		endcase
		w  = ($urandom_range(19) == 0) ? 12'd0 : 12'($urandom_range(1, 20));
		h  = ($urandom_range(19) == 0) ? 12'd0 : 12'($urandom_range(1, 8));
		es = limit_range(s, 1, 8);
		ew = limit_range(w, 1, 2048);
		eh = limit_range(h, 1, 2048);
		set_geometry(w, h, s, pick_out_size(ew / es), pick_out_size(eh / es),
			1'($urandom_range(1)));
	endtask

	// sum channel: check each transfer, then choose the next out_ready
	initial begin : sum_sink
		area_sum_t want;
		int        hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (sums_due.size() == 0) begin
					report_mismatch($sformatf("sum %0d at row %0d col %0d with nothing due",
						sum, out_row, out_col));
				end else begin
					want = sums_due.pop_front();
					if (sum !== want.total)
						report_mismatch($sformatf("sum %0d, predicted %0d at row %0d col %0d",
							sum, want.total, want.row, want.col));
					if (out_row !== want.row)
						report_mismatch($sformatf("out_row %0d, predicted %0d",
							out_row, want.row));
					if (out_col !== want.col)
						report_mismatch($sformatf("out_col %0d, predicted %0d",
							out_col, want.col));
					if (last !== want.last)
						report_mismatch($sformatf("last %0b, predicted %0b at row %0d col %0d",
							last, want.last, want.row, want.col));
				end
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = LONG_HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("integral_image_builder: mismatch");
			$finish;
		end
	end

	// stimulus
	initial begin : stimulus
		int mode_end;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed steps, sender sparse and receiver slow
		tx_idle_pct = 18;
		rx_idle_pct = 80;
		foreach (plan[i]) begin
			if (plan[i].kind == STEP_WRITE)
				write_register(plan[i].reg_idx, plan[i].value);
			else
				send_pixel(plan[i].cb_v, plan[i].cr_v, plan[i].typed, plan[i].want);
		end

		// random geometries under each idling mix
		for (int m = 0; m < 3; m++) begin
			tx_idle_pct = (m == 0) ? 18 : (m == 1) ? 80 : 0;
			rx_idle_pct = (m == 0) ? 80 : (m == 1) ? 18 : 0;
			mode_end    = pixels_sent + PIXELS_PER_MODE;
			while (pixels_sent < mode_end) begin
				pick_geometry();
				repeat ($urandom_range(1, 2)) send_frame();
			end
		end

		// row wider than the line store with a long receiver hold, then a narrow column
		set_geometry(12'd1030, 12'd1, 4'd1, 12'hFFF, 12'd1, 1'($urandom_range(1)));
		hold_request = 1'b1;
		send_frame();
		set_geometry(12'd1, 12'd40, 4'd1, 12'd1, 12'hFFF, 1'($urandom_range(1)));
		send_frame();

		// drain
		in_valid <= 1'b0;
		while (sums_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("integral_image_builder: match");
		else
			$display("integral_image_builder: mismatch");
		$finish;
	end

endmodule

[files.f]
+incdir+hdl
hdl/iib_pkg.sv
hdl/iib_ram.sv
hdl/integral_image_builder.sv
hdl/iib_checker.sv
tb/tb_integral_image_builder.sv
